>>> hdl/bblt_pkg.sv
// Shared constants and controller/datapath link types for the byte budget LRU tracker.
package bblt_pkg;

   localparam int ENTRIES   = 16;
   localparam int KEY_WIDTH = 16;
   localparam int SIZE_W    = 32;
   localparam int TOTAL_W   = 33;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int CNT_W     = $clog2(ENTRIES + 1);

   localparam logic [SIZE_W-1:0] BUDGET_RESET = SIZE_W'(1024 * 1024 * 500);

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;       // capture request word, restart scan
      logic scan_step;  // advance scan index
      logic sel_back;   // read port addresses the back entry
      logic promote;    // move hit entry to front, emit hit status
      logic add;        // add request size to running total
      logic evict;      // drop back entry, emit eviction
      logic insert;     // push request to front, emit final status
   } bblt_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic match;
      logic scan_done;
      logic over_budget;
      logic list_full;
      logic list_empty;
      logic slot_free;
   } bblt_stat_type;

endpackage

>>> hdl/bblt_channels.sv
// Request and response channel interfaces with valid/ready handshake.
interface bblt_req_if import bblt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [KEY_WIDTH-1:0]  request_key;
   logic [SIZE_W-1:0]     request_size;

   modport source (output valid, output request_key, output request_size, input ready);
   modport sink   (input valid, input request_key, input request_size, output ready);
endinterface

interface bblt_rsp_if import bblt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  is_eviction;
   logic [KEY_WIDTH-1:0]  evicted_key;
   logic                  was_hit;
   logic [TOTAL_W-1:0]    bytes_in_use;
   logic                  last_of_run;

   modport source (output valid, output is_eviction, output evicted_key, output was_hit,
                   output bytes_in_use, output last_of_run, input ready);
   modport sink   (input valid, input is_eviction, input evicted_key, input was_hit,
                   input bytes_in_use, input last_of_run, output ready);
endinterface

>>> hdl/byte_budget_lru_tracker.sv
// Top level of the byte budget LRU tracker: controller plus datapath.
//
// Requests arrive on req_bus (key and byte size) with a valid/ready handshake;
// results leave on rsp_bus the same way. Each request yields zero or more
// eviction words (is_eviction = 1, key of the dropped entry, new total) and
// then one final status word (last_of_run = 1, was_hit, total).
// The byte budget is written through csr_we/csr_wdata; write it only while idle, the block does not enforce this.
// A request is accepted in the idle state, then the list is scanned one entry per
// cycle; a hit then promotes its entry, a miss adds the size, evicts from the back
// as needed and inserts; the scan and the shared read port of the entry list set
// how long a request takes.
// A new request is taken once the final word is loaded into the response
// register, even if the receiver has not yet taken it.
// A stalled receiver holds the response register and the sequencer waits
// before producing the next word; nothing is lost.
// Reset (synchronous, active high) empties the list, clears the total and
// restores the budget to 500 MiB; it needs no clearing pass.
module byte_budget_lru_tracker import bblt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [SIZE_W-1:0] csr_wdata,
   bblt_req_if.sink          req_bus,
   bblt_rsp_if.source        rsp_bus
);

   bblt_cmd_type  cmd;
   bblt_stat_type stat;
   logic          req_ready;

   assign req_bus.ready = req_ready;

   bblt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bblt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_key   (req_bus.request_key),
      .req_size  (req_bus.request_size),
      .cmd       (cmd),
      .stat      (stat),
      .rsp       (rsp_bus)
   );

endmodule

>>> hdl/bblt_ctrl.sv
// Sequencing state machine: scan, promote, evict and insert steps.
module bblt_ctrl import bblt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  bblt_stat_type stat,
   output bblt_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HIT,
      ST_ADD,
      ST_CHECK,
      ST_EVICT,
      ST_INSERT
   } state_type;

   state_type state_ff, state_in;

   // decode commands and next state
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = ST_ADD;
            end else if (stat.match) begin
               state_in = ST_HIT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_HIT: begin
            if (stat.slot_free) begin
               cmd.promote = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // a full list drops its back entry as well as an overdrawn budget
            if ((stat.over_budget && !stat.list_empty) || stat.list_full) begin
               state_in = ST_EVICT;
            end else begin
               state_in = ST_INSERT;
            end
         end
         ST_EVICT: begin
            cmd.sel_back = 1'b1;
            if (stat.slot_free) begin
               cmd.evict = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_INSERT: begin
            if (stat.slot_free) begin
               cmd.insert = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/bblt_datapath.sv
// Entry list registers, running total, budget register and response register.
module bblt_datapath import bblt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [SIZE_W-1:0]    csr_wdata,
   input  logic [KEY_WIDTH-1:0] req_key,
   input  logic [SIZE_W-1:0]    req_size,
   input  bblt_cmd_type         cmd,
   output bblt_stat_type        stat,
   bblt_rsp_if.source           rsp
);

   logic [KEY_WIDTH-1:0] keys_ff  [ENTRIES];
   logic [KEY_WIDTH-1:0] keys_in  [ENTRIES];
   logic [SIZE_W-1:0]    sizes_ff [ENTRIES];
   logic [SIZE_W-1:0]    sizes_in [ENTRIES];

   logic [SIZE_W-1:0]    budget_ff, budget_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [CNT_W-1:0]     scan_idx_ff, scan_idx_in;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [SIZE_W-1:0]    size_ff;

   logic                 out_valid_ff, out_valid_in;
   logic                 out_evict_ff;
   logic [KEY_WIDTH-1:0] out_key_ff;
   logic                 out_hit_ff;
   logic [TOTAL_W-1:0]   out_total_ff;
   logic                 out_last_ff;

   logic [CNT_W-1:0]     back_cnt;
   logic [IDX_W-1:0]     rd_idx;
   logic [KEY_WIDTH-1:0] rd_key;
   logic [SIZE_W-1:0]    rd_size;
   logic [TOTAL_W-1:0]   total_sub;
   logic                 emit;

   // single read port: scan position or back entry
   assign back_cnt  = count_ff - CNT_W'(1);
   assign rd_idx    = cmd.sel_back ? back_cnt[IDX_W-1:0] : scan_idx_ff[IDX_W-1:0];
   assign rd_key    = keys_ff[rd_idx];
   assign rd_size   = sizes_ff[rd_idx];
   assign total_sub = total_ff - {1'b0, rd_size};
   assign emit      = cmd.promote | cmd.evict | cmd.insert;

   // status to the controller
   assign stat.match       = (rd_key == key_ff);
   assign stat.scan_done   = (scan_idx_ff == count_ff);
   assign stat.over_budget = (total_ff > {1'b0, budget_ff});
   assign stat.list_full   = (count_ff == CNT_W'(ENTRIES));
   assign stat.list_empty  = (count_ff == '0);
   assign stat.slot_free   = !out_valid_ff || rsp.ready;

   // next values of control registers
   always_comb begin
      budget_in    = csr_we ? csr_wdata : budget_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      scan_idx_in  = scan_idx_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      if (cmd.load) begin
         scan_idx_in = '0;
      end
      if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + CNT_W'(1);
      end
      if (cmd.add) begin
         total_in = total_ff + {1'b0, size_ff};
      end
      if (cmd.evict) begin
         total_in = total_sub;
         count_in = back_cnt;
      end
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (emit) begin
         out_valid_in = 1'b1;
      end
   end

   // shift entries toward the back for a promote or an insert
   always_comb begin
      for (int j = 0; j < ENTRIES; j++) begin
         keys_in[j]  = keys_ff[j];
         sizes_in[j] = sizes_ff[j];
         if (cmd.insert || (cmd.promote && (CNT_W'(j) <= scan_idx_ff))) begin
            if (j == 0) begin
               keys_in[j]  = key_ff;
               sizes_in[j] = cmd.promote ? rd_size : size_ff;
            end else begin
               keys_in[j]  = keys_ff[j-1];
               sizes_in[j] = sizes_ff[j-1];
            end
         end
      end
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff    <= BUDGET_RESET;
         count_ff     <= '0;
         total_ff     <= '0;
         scan_idx_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         budget_ff    <= budget_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         scan_idx_ff  <= scan_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold payload: entries, request word, response word
   always_ff @(posedge clock) begin
      keys_ff  <= keys_in;
      sizes_ff <= sizes_in;
      if (cmd.load) begin
         key_ff  <= req_key;
         size_ff <= req_size;
      end
      if (emit) begin
         out_evict_ff <= cmd.evict;
         out_key_ff   <= cmd.evict ? rd_key : '0;
         out_hit_ff   <= cmd.promote;
         out_total_ff <= cmd.evict ? total_sub : total_ff;
         out_last_ff  <= !cmd.evict;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.is_eviction  = out_evict_ff;
   assign rsp.evicted_key  = out_key_ff;
   assign rsp.was_hit      = out_hit_ff;
   assign rsp.bytes_in_use = out_total_ff;
   assign rsp.last_of_run  = out_last_ff;

   // list never holds more than its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("entry count above capacity");

   // an eviction needs a resident entry
   a_evict_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.evict |-> (count_ff != '0))
      else $error("eviction from empty list");

   // a promote only follows a key match inside the list
   a_promote_match: assert property (@(posedge clock) disable iff (reset)
      cmd.promote |-> (stat.match && !stat.scan_done))
      else $error("promote without a matching entry");

   // an insert grows the list by exactly one
   a_insert_grow: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the list");

   // a response word is never overwritten while the receiver stalls
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp.ready) |-> !emit)
      else $error("response word overwritten while stalled");

endmodule

>>> tb/tb_byte_budget_lru_tracker.sv
// Testbench for the byte budget LRU tracker: random and directed requests against a local LRU model.
`timescale 1ns / 100ps

module tb_byte_budget_lru_tracker;
   import bblt_pkg::*;

   localparam int SETTLE_CYCLES = 24;
   localparam int RUN_LIMIT_NS  = 6_000_000;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 50;
   localparam int POOL_SIZE     = 20;

   // one request word and one expected result word
   typedef struct packed {
      logic [KEY_WIDTH-1:0] key;
      logic [SIZE_W-1:0]    size;
   } lru_request_type;

   typedef struct packed {
      logic                 is_eviction;
      logic [KEY_WIDTH-1:0] evicted_key;
      logic                 was_hit;
      logic [TOTAL_W-1:0]   bytes_in_use;
      logic                 last_of_run;
   } lru_word_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_we;
   logic [SIZE_W-1:0] csr_wdata;

   bblt_req_if req_if ();
   bblt_rsp_if rsp_if ();

   byte_budget_lru_tracker u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // resident list as the tracker should hold it, most recent first
   logic [KEY_WIDTH-1:0] res_keys [ENTRIES];
   logic [SIZE_W-1:0]    res_sizes[ENTRIES];
   int                   res_count;
   logic [TOTAL_W-1:0]   res_total;
   logic [SIZE_W-1:0]    budget_shadow;

   lru_request_type request_backlog[$];
   lru_word_type    expected_words[$];
   lru_word_type    want_word;

   bit idle_off;
   int fail_count;
   int requests_accepted;
   int words_checked;
   int evictions_seen;
   int hits_seen;
   int budget_writes;
   logic [KEY_WIDTH-1:0] key_pool[POOL_SIZE];

   // drop the back entry and queue its eviction word
   task automatic drop_back_entry();
      lru_word_type w;
      res_count = res_count - 1;
      res_total = res_total - {1'b0, res_sizes[res_count]};
      w.is_eviction  = 1'b1;
      w.evicted_key  = res_keys[res_count];
      w.was_hit      = 1'b0;
      w.bytes_in_use = res_total;
      w.last_of_run  = 1'b0;
      expected_words = {expected_words, w};
   endtask

   // work out the words one accepted request should produce
   task automatic lru_track_request(input logic [KEY_WIDTH-1:0] key,
                                    input logic [SIZE_W-1:0] size);
      int           pos;
      lru_word_type w;
      logic [SIZE_W-1:0] held;
      pos = -1;
      for (int i = 0; i < res_count; i++)
         if (pos < 0 && res_keys[i] == key) pos = i;
      w.is_eviction = 1'b0;
      w.evicted_key = '0;
      w.last_of_run = 1'b1;
      if (pos >= 0) begin
         // hit: move to front, total untouched
         held = res_sizes[pos];
         for (int i = pos; i > 0; i--) begin
            res_keys[i]  = res_keys[i-1];
            res_sizes[i] = res_sizes[i-1];
         end
         res_keys[0]  = key;
         res_sizes[0] = held;
         w.was_hit      = 1'b1;
         w.bytes_in_use = res_total;
      end else begin
         // miss: add, evict down to budget, make room, insert
         res_total = res_total + {1'b0, size};
         while (res_total > {1'b0, budget_shadow} && res_count > 0) drop_back_entry();
         if (res_count >= ENTRIES) drop_back_entry();
         for (int i = res_count; i > 0; i--) begin
            res_keys[i]  = res_keys[i-1];
            res_sizes[i] = res_sizes[i-1];
         end
         res_keys[0]  = key;
         res_sizes[0] = size;
         res_count    = res_count + 1;
         w.was_hit      = 1'b0;
         w.bytes_in_use = res_total;
      end
      expected_words = {expected_words, w};
   endtask

   // request driver: predict on acceptance, then present the next word
   always @(posedge clock) begin : drive_requests
      int send_gap;
      lru_request_type rq;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
         res_count = 0;
         res_total = '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            lru_track_request(req_if.request_key, req_if.request_size);
            requests_accepted++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
               rq = request_backlog.pop_front();
               req_if.valid        <= 1'b1;
               req_if.request_key  <= rq.key;
               req_if.request_size <= rq.size;
               if (!idle_off && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 17);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compare each accepted word with the oldest expectation
   always @(posedge clock) begin : check_results
      int stall_left;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word: is_eviction=%0b evicted_key=%h bytes_in_use=%h",
                      rsp_if.is_eviction, rsp_if.evicted_key, rsp_if.bytes_in_use);
               fail_count++;
            end else begin
               want_word = expected_words.pop_front();
               words_checked++;
               if (want_word.is_eviction) evictions_seen++;
               if (want_word.was_hit) hits_seen++;
               if (rsp_if.is_eviction !== want_word.is_eviction) begin
                  $error("is_eviction: expected %0b, got %0b",
                         want_word.is_eviction, rsp_if.is_eviction);
                  fail_count++;
               end
               if (rsp_if.evicted_key !== want_word.evicted_key) begin
                  $error("evicted_key: expected %h, got %h",
                         want_word.evicted_key, rsp_if.evicted_key);
                  fail_count++;
               end
               if (rsp_if.was_hit !== want_word.was_hit) begin
                  $error("was_hit: expected %0b, got %0b", want_word.was_hit, rsp_if.was_hit);
                  fail_count++;
               end
               if (rsp_if.bytes_in_use !== want_word.bytes_in_use) begin
                  $error("bytes_in_use: expected %h, got %h",
                         want_word.bytes_in_use, rsp_if.bytes_in_use);
                  fail_count++;
               end
               if (rsp_if.last_of_run !== want_word.last_of_run) begin
                  $error("last_of_run: expected %0b, got %0b",
                         want_word.last_of_run, rsp_if.last_of_run);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!idle_off && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 17);
         end
      end
   end

   task automatic queue_request(input logic [KEY_WIDTH-1:0] key, input logic [SIZE_W-1:0] size);
      lru_request_type rq;
      rq.key  = key;
      rq.size = size;
      request_backlog = {request_backlog, rq};
   endtask

   // hold until every request is taken and every word has come back
   task automatic wait_drained();
      while (request_backlog.size() != 0 || req_if.valid || expected_words.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_budget(input logic [SIZE_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      budget_shadow = value;
      budget_writes++;
      @(negedge clock);
   endtask

   // sizes scaled to the budget so that several entries stay resident
   function automatic logic [SIZE_W-1:0] pick_size(input logic [SIZE_W-1:0] b);
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return '0;
         2: return b;
         default: return (b < 8) ? SIZE_W'($urandom_range(0, 3)) : $urandom_range(0, b / 6);
      endcase
   endfunction

   initial begin : run_stimulus
      logic [SIZE_W-1:0] phase_budget[PHASES];
      logic [KEY_WIDTH-1:0] key;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_wdata           = '0;
      budget_shadow       = BUDGET_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: zero size, oversized miss, sum past 32 bits, hit, full list, hits at middle and back
      queue_request(16'h0000, 32'h0000_0000);
      queue_request(16'hFFFF, 32'hFFFF_FFFF);
      queue_request(16'h0001, 32'd100);
      queue_request(16'h0001, 32'hFFFF_FFFF);
      for (int k = 2; k <= 17; k++) queue_request(KEY_WIDTH'(k), 32'd1000);
      queue_request(16'h0005, 32'd7);
      queue_request(16'h0002, 32'd7);
      queue_request(16'hAAAA, 32'h5555_5555);
      queue_request(16'h5555, 32'hAAAA_AAAA);
      wait_drained();

      phase_budget[0] = 32'hFFFF_FFFF;
      phase_budget[1] = 32'd0;
      phase_budget[2] = 32'd3000;
      phase_budget[3] = 32'd1000;
      phase_budget[4] = $urandom();
      phase_budget[5] = BUDGET_RESET;

      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) idle_off = 1'b1;
         write_budget(phase_budget[p]);
         // a hit straight after a budget change must evict nothing
         if (res_count > 0)
            queue_request(res_keys[(p % 2) ? 0 : res_count - 1], $urandom());
         // largest budget: push the sum towards its widest value
         if (p == 0) begin
            queue_request(16'h0100, 32'hFFFF_FFFF);
            queue_request(16'h0101, 32'hFFFF_FFFF);
         end
         for (int k = 0; k < POOL_SIZE; k++) key_pool[k] = $urandom();
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 9) == 0) key = $urandom();
            else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            queue_request(key, pick_size(budget_shadow));
            if (p == 1 && i == PHASE_ITEMS / 2) wait_drained();
         end
         wait_drained();
      end

      $display("%0d requests, %0d words checked: %0d evictions, %0d hits",
               requests_accepted, words_checked, evictions_seen, hits_seen);
      $display("%0d budget settings from zero to all ones, with idling on both channels",
               budget_writes);
      if (fail_count == 0)
         $display("tb_byte_budget_lru_tracker passed");
      else
         $display("tb_byte_budget_lru_tracker failed");
      $finish;
   end

   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("tb_byte_budget_lru_tracker failed");
      $finish;
   end

endmodule
